// ===== rtl/core/obrb_pkg.sv =====
// ----------------------------------------------------------------------------
// obrb_pkg
// Shared constants, types and helper functions of the overwriting byte ring
// buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package obrb_pkg;

  // Store geometry
  localparam int DEPTH  = 4096;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CAP_W  = ADDR_W + 1;
  localparam int DATA_W = 8;
  localparam int KIND_W = 2;

  // Longest peek burst
  localparam int BURST  = 64;
  localparam int LEFT_W = $clog2(BURST + 1);

  // Modulo unit: index plus shift count, reduced one bit per cycle
  localparam int SUM_W  = ADDR_W + 2;
  localparam int DIV_W  = CAP_W + SUM_W - 1;
  localparam int STEP_W = $clog2(SUM_W);

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PEEK   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SHIFT  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REWIND = 2'd3;

  // Request to the modulo unit
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CAP_W-1:0] divisor;
  } mod_req_t;

  // Answer of the modulo unit
  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] result;
  } mod_rsp_t;

  // Capacity in use: zero acts as one, anything above the store as the store
  function automatic logic [CAP_W-1:0] cap_clamp(input logic [CAP_W-1:0] value);
    logic [CAP_W-1:0] res;
    if (value == '0) begin
      res = CAP_W'(1);
    end else if (value > CAP_W'(DEPTH)) begin
      res = CAP_W'(DEPTH);
    end else begin
      res = value;
    end
    return res;
  endfunction

  // Advance an index by one around the ring
  function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] idx,
                                                 input logic [CAP_W-1:0]  cap);
    logic [CAP_W-1:0] sum;
    sum = {1'b0, idx} + CAP_W'(1);
    return (sum == cap) ? '0 : sum[ADDR_W-1:0];
  endfunction

  // Bytes held: capacity when full, else the index distance around the ring
  function automatic logic [CAP_W-1:0] occ_of(input logic [ADDR_W-1:0] wr_idx,
                                              input logic [ADDR_W-1:0] rd_idx,
                                              input logic              full,
                                              input logic [CAP_W-1:0]  cap);
    logic [CAP_W-1:0] res;
    if (full) begin
      res = cap;
    end else if (wr_idx >= rd_idx) begin
      res = {1'b0, wr_idx} - {1'b0, rd_idx};
    end else begin
      res = cap + {1'b0, wr_idx} - {1'b0, rd_idx};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/obrb_if.sv =====
// ----------------------------------------------------------------------------
// obrb_if
// Valid/ready channels of the ring buffer: request, result and capacity write.
// ----------------------------------------------------------------------------
`default_nettype none

// Request channel
interface obrb_in_if;
  logic                            valid;
  logic                            ready;
  logic [obrb_pkg::KIND_W-1:0]     kind;
  logic [obrb_pkg::DATA_W-1:0]     data_in;
  logic [obrb_pkg::CAP_W-1:0]      count;

  modport source (output valid, kind, data_in, count, input ready);
  modport sink   (input valid, kind, data_in, count, output ready);
endinterface

// Result channel
interface obrb_out_if;
  logic                            valid;
  logic                            ready;
  logic [obrb_pkg::DATA_W-1:0]     data_out;
  logic                            has_data;
  logic                            last;
  logic [obrb_pkg::CAP_W-1:0]      occupancy;
  logic                            is_full;
  logic                            is_empty;

  modport source (output valid, data_out, has_data, last, occupancy, is_full,
                  is_empty, input ready);
  modport sink   (input valid, data_out, has_data, last, occupancy, is_full,
                  is_empty, output ready);
endinterface

// Capacity register write channel
interface obrb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [obrb_pkg::CAP_W-1:0]      capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/obrb_ram.sv =====
// ----------------------------------------------------------------------------
// obrb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module obrb_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/obrb_mod.sv =====
// ----------------------------------------------------------------------------
// obrb_mod
// Restoring modulo unit: reduces index plus count by the capacity, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module obrb_mod (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire obrb_pkg::mod_req_t req,
  output obrb_pkg::mod_rsp_t      rsp
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [obrb_pkg::SUM_W-1:0]      rem_r, rem_nxt;
  logic [obrb_pkg::DIV_W-1:0]      div_r, div_nxt;
  logic [obrb_pkg::STEP_W-1:0]     step_r, step_nxt;

  // One compare and subtract per cycle, divisor walking down
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    step_nxt = step_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      rem_nxt  = req.dividend;
      div_nxt  = {req.divisor, (obrb_pkg::SUM_W-1)'(0)};
      step_nxt = obrb_pkg::STEP_W'(obrb_pkg::SUM_W - 1);
    end else if (busy_r) begin
      if (obrb_pkg::DIV_W'(rem_r) >= div_r) begin
        rem_nxt = rem_r - div_r[obrb_pkg::SUM_W-1:0];
      end
      div_nxt = div_r >> 1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - obrb_pkg::STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    step_r <= step_nxt;
  end

  // Remainder is below the capacity, so it fits an index
  assign rsp.done   = done_r;
  assign rsp.result = rem_r[obrb_pkg::ADDR_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/overwriting_byte_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// overwriting_byte_ring_buffer
// Byte ring buffer over a 4096-byte store that overwrites its oldest data,
// with peek, discard and rewind requests and a capacity register.
// ----------------------------------------------------------------------------
// A write, a rewind, a discard of zero bytes and a peek of nothing are answered
// straight from the idle state, so writes stream at one byte per clock while
// results are taken. A peek of n bytes (n at most 64) first reads the store,
// then returns one byte per cycle from the single read port while results are
// taken. A discard of a non-zero count waits on the modulo unit, which reduces
// the read index plus count one bit per cycle over 14 steps. The store is not
// cleared after reset and needs no clearing pass; capacity writes are taken in
// the idle state and empty the ring.
`default_nettype none

module overwriting_byte_ring_buffer (
  input  wire logic   clk,
  input  wire logic   rst_n,
  obrb_in_if.sink     in_ch,
  obrb_out_if.source  out_ch,
  obrb_cfg_if.sink    cfg_ch
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PEEK  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;

  logic [1:0]                      state_r, state_nxt;
  logic [obrb_pkg::ADDR_W-1:0]     wr_idx_r, wr_idx_nxt;
  logic [obrb_pkg::ADDR_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                            full_r, full_nxt;
  logic [obrb_pkg::CAP_W-1:0]      cap_r, cap_nxt;
  logic [obrb_pkg::ADDR_W-1:0]     pos_r, pos_nxt;
  logic [obrb_pkg::LEFT_W-1:0]     left_r, left_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [obrb_pkg::DATA_W-1:0]     out_data_r, out_data_nxt;
  logic                            out_has_r, out_has_nxt;
  logic                            out_last_r, out_last_nxt;
  logic [obrb_pkg::CAP_W-1:0]      out_occ_r, out_occ_nxt;
  logic                            out_full_r, out_full_nxt;
  logic                            out_empty_r, out_empty_nxt;

  logic                            out_free;
  logic                            in_acc;
  logic                            cfg_acc;
  logic [obrb_pkg::CAP_W-1:0]      occ_cur;
  logic [obrb_pkg::CAP_W-1:0]      peek_n;

  logic                            ram_we;
  logic [obrb_pkg::ADDR_W-1:0]     ram_waddr;
  logic                            ram_re;
  logic [obrb_pkg::ADDR_W-1:0]     ram_raddr;
  logic [obrb_pkg::DATA_W-1:0]     ram_rdata;

  obrb_pkg::mod_req_t              mod_req;
  obrb_pkg::mod_rsp_t              mod_rsp;

  logic                            load;
  logic [obrb_pkg::DATA_W-1:0]     ld_data;
  logic                            ld_has;
  logic                            ld_last;

  // Handshakes
  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE) && out_free;
  assign cfg_ch.ready = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;

  // Occupancy now and peek length, saturated at occupancy and burst
  always_comb begin
    occ_cur = obrb_pkg::occ_of(wr_idx_r, rd_idx_r, full_r, cap_r);
    peek_n  = in_ch.count;
    if (peek_n > occ_cur) begin
      peek_n = occ_cur;
    end
    if (peek_n > obrb_pkg::CAP_W'(obrb_pkg::BURST)) begin
      peek_n = obrb_pkg::CAP_W'(obrb_pkg::BURST);
    end
  end

  // Request sequencer
  always_comb begin
    state_nxt        = state_r;
    wr_idx_nxt       = wr_idx_r;
    rd_idx_nxt       = rd_idx_r;
    full_nxt         = full_r;
    cap_nxt          = cap_r;
    pos_nxt          = pos_r;
    left_nxt         = left_r;
    ram_we           = 1'b0;
    ram_waddr        = wr_idx_r;
    ram_re           = 1'b0;
    ram_raddr        = pos_r;
    mod_req.start    = 1'b0;
    mod_req.dividend = obrb_pkg::SUM_W'(rd_idx_r) + obrb_pkg::SUM_W'(in_ch.count);
    mod_req.divisor  = cap_r;
    load             = 1'b0;
    ld_data          = '0;
    ld_has           = 1'b0;
    ld_last          = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_ch.kind)
            obrb_pkg::KIND_WRITE: begin
              ram_we     = 1'b1;
              wr_idx_nxt = obrb_pkg::wrap_inc(wr_idx_r, cap_r);
              full_nxt   = full_r || ((occ_cur + obrb_pkg::CAP_W'(1)) >= cap_r);
              if (full_nxt) begin
                rd_idx_nxt = wr_idx_nxt;
              end
              load = 1'b1;
            end
            obrb_pkg::KIND_PEEK: begin
              if (peek_n == '0) begin
                load = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = rd_idx_r;
                pos_nxt   = obrb_pkg::wrap_inc(rd_idx_r, cap_r);
                left_nxt  = peek_n[obrb_pkg::LEFT_W-1:0];
                state_nxt = ST_PEEK;
              end
            end
            obrb_pkg::KIND_SHIFT: begin
              if (in_ch.count == '0) begin
                load = 1'b1;
              end else begin
                mod_req.start = 1'b1;
                state_nxt     = ST_SHIFT;
              end
            end
            default: begin
              wr_idx_nxt = '0;
              rd_idx_nxt = '0;
              full_nxt   = 1'b0;
              load       = 1'b1;
            end
          endcase
        end
      end
      ST_PEEK: begin
        // one byte per cycle while the result register is free, next read issued as this one leaves
        if (out_free) begin
          load     = 1'b1;
          ld_data  = ram_rdata;
          ld_has   = 1'b1;
          ld_last  = (left_r == obrb_pkg::LEFT_W'(1));
          left_nxt = left_r - obrb_pkg::LEFT_W'(1);
          if (left_r == obrb_pkg::LEFT_W'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            ram_re  = 1'b1;
            pos_nxt = obrb_pkg::wrap_inc(pos_r, cap_r);
          end
        end
      end
      ST_SHIFT: begin
        if (mod_rsp.done && out_free) begin
          rd_idx_nxt = mod_rsp.result;
          full_nxt   = 1'b0;
          load       = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Capacity write empties the ring
    if (cfg_acc) begin
      cap_nxt    = obrb_pkg::cap_clamp(cfg_ch.capacity);
      wr_idx_nxt = '0;
      rd_idx_nxt = '0;
      full_nxt   = 1'b0;
    end
  end

  // Result register, status taken from the state after the request
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_has_nxt   = out_has_r;
    out_last_nxt  = out_last_r;
    out_occ_nxt   = out_occ_r;
    out_full_nxt  = out_full_r;
    out_empty_nxt = out_empty_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = ld_data;
      out_has_nxt   = ld_has;
      out_last_nxt  = ld_last;
      out_occ_nxt   = obrb_pkg::occ_of(wr_idx_nxt, rd_idx_nxt, full_nxt, cap_nxt);
      out_full_nxt  = full_nxt;
      out_empty_nxt = !full_nxt && (wr_idx_nxt == rd_idx_nxt);
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      full_r      <= 1'b0;
      cap_r       <= obrb_pkg::CAP_W'(obrb_pkg::DEPTH);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      full_r      <= full_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r       <= pos_nxt;
    left_r      <= left_nxt;
    out_data_r  <= out_data_nxt;
    out_has_r   <= out_has_nxt;
    out_last_r  <= out_last_nxt;
    out_occ_r   <= out_occ_nxt;
    out_full_r  <= out_full_nxt;
    out_empty_r <= out_empty_nxt;
  end

  // Byte store
  obrb_ram #(
    .ADDR_W (obrb_pkg::ADDR_W),
    .DATA_W (obrb_pkg::DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_ch.data_in),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Read index reduction for discards
  obrb_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  assign out_ch.valid     = out_valid_r;
  assign out_ch.data_out  = out_data_r;
  assign out_ch.has_data  = out_has_r;
  assign out_ch.last      = out_last_r;
  assign out_ch.occupancy = out_occ_r;
  assign out_ch.is_full   = out_full_r;
  assign out_ch.is_empty  = out_empty_r;

endmodule

`default_nettype wire

// ===== rtl/core/obrb_chk.sv =====
// ----------------------------------------------------------------------------
// obrb_chk
// Port-level checks of the ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module obrb_chk (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic                        in_ready,
  input  wire logic                        out_valid,
  input  wire logic                        out_ready,
  input  wire logic [obrb_pkg::DATA_W-1:0] data_out,
  input  wire logic                        has_data,
  input  wire logic                        last,
  input  wire logic [obrb_pkg::CAP_W-1:0]  occupancy,
  input  wire logic                        is_full,
  input  wire logic                        is_empty
);

  // Empty exactly when nothing is held, and never while full
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (is_empty == (occupancy == '0)) && !(is_full && is_empty))
    else $error("is_empty disagrees with occupancy or is_full");

  // A peeked byte never comes from an empty ring
  a_data_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && has_data |-> !is_empty)
    else $error("byte returned from an empty ring");

  // A status-only result always closes its request
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !has_data |-> last)
    else $error("status result without last");

  // No request taken while a result is stuck
  a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid || out_ready)
    else $error("request taken while the result is stalled");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(data_out) && $stable(last)
      && $stable(occupancy))
    else $error("stalled result changed");

endmodule

bind overwriting_byte_ring_buffer obrb_chk u_obrb_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .data_out  (out_ch.data_out),
  .has_data  (out_ch.has_data),
  .last      (out_ch.last),
  .occupancy (out_ch.occupancy),
  .is_full   (out_ch.is_full),
  .is_empty  (out_ch.is_empty)
);

`default_nettype wire

// ===== tb/sv/overwriting_byte_ring_buffer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// overwriting_byte_ring_buffer_test
// Self-checking bench for the overwriting byte ring buffer. A mirror of the
// ring (store, indices, full flag, capacity) predicts every result of every
// request. Directed tests cover the empty and full edges, overwrite, wrapped
// discards and capacity clamping. A long output hold-off stalls the block.
// Random phases then run write bursts with peeks, discards, rewinds and
// noise under several capacities and idling patterns.
// ----------------------------------------------------------------------------

module overwriting_byte_ring_buffer_test;

  // Geometry of the block
  localparam int DATA_W = obrb_pkg::DATA_W;
  localparam int CAP_W  = obrb_pkg::CAP_W;
  localparam int ADDR_W = obrb_pkg::ADDR_W;
  localparam int KIND_W = obrb_pkg::KIND_W;
  localparam int DEPTH  = obrb_pkg::DEPTH;
  localparam int BURST  = obrb_pkg::BURST;

  localparam int unsigned CYCLE_LIMIT    = 1000000;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned MAX_GAP        = 50;
  localparam int unsigned HOLDOFF_CYCLES = 400;
  localparam int unsigned COUNT_MAX      = (1 << CAP_W) - 1;

  // One result as the block reports it
  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              has_data;
    logic              last;
    logic [CAP_W-1:0]  occupancy;
    logic              is_full;
    logic              is_empty;
  } ring_result_t;

  logic clk = 1'b0;
  logic rst_n;

  obrb_in_if  in_ch ();
  obrb_out_if out_ch ();
  obrb_cfg_if cfg_ch ();

  overwriting_byte_ring_buffer u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the ring
  logic [DATA_W-1:0] mirror_bytes [DEPTH];
  bit                mirror_written [DEPTH];
  int unsigned       wr_idx;
  int unsigned       rd_idx;
  bit                ring_full;
  logic [CAP_W-1:0]  cap_reg;

  ring_result_t pending_results [$];

  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned requests_sent;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          holdoff_kick;
  bit          holdoff_seen;
  int unsigned holdoff_left;

  function automatic int unsigned cap_eff();
    if (cap_reg == '0) return 1;
    if (cap_reg > CAP_W'(DEPTH)) return DEPTH;
    return 32'(cap_reg);
  endfunction

  function automatic int unsigned occ_now();
    if (ring_full) return cap_eff();
    if (wr_idx >= rd_idx) return wr_idx - rd_idx;
    return cap_eff() + wr_idx - rd_idx;
  endfunction

  // Queue one expected result carrying the current status
  function automatic void push_result(logic [DATA_W-1:0] data, logic has, logic last);
    ring_result_t r;
    r.data_out  = data;
    r.has_data  = has;
    r.last      = last;
    r.occupancy = CAP_W'(occ_now());
    r.is_full   = ring_full;
    r.is_empty  = !ring_full && (wr_idx == rd_idx);
    pending_results.push_back(r);
  endfunction

  function automatic void empty_mirror();
    wr_idx    = 0;
    rd_idx    = 0;
    ring_full = 1'b0;
  endfunction

  // Apply one request to the mirror and queue what it causes
  function automatic void mirror_request(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] data,
                                         logic [CAP_W-1:0] count);
    int unsigned cap;
    int unsigned occ;
    int unsigned n;
    int unsigned i;
    cap = cap_eff();
    wr_idx = wr_idx % cap;
    rd_idx = rd_idx % cap;
    case (kind)
      obrb_pkg::KIND_WRITE: begin
        occ = occ_now();
        mirror_bytes[ADDR_W'(wr_idx)]   = data;
        mirror_written[ADDR_W'(wr_idx)] = 1'b1;
        wr_idx = (wr_idx + 1) % cap;
        if (occ + 1 >= cap) ring_full = 1'b1;
        if (ring_full) rd_idx = wr_idx;
        push_result('0, 1'b0, 1'b1);
      end
      obrb_pkg::KIND_PEEK: begin
        n = 32'(count);
        occ = occ_now();
        if (n > occ) n = occ;
        if (n > BURST) n = BURST;
        if (n == 0) begin
          push_result('0, 1'b0, 1'b1);
        end else begin
          for (i = 0; i < n; i++) begin
            push_result(mirror_bytes[ADDR_W'((rd_idx + i) % cap)], 1'b1, (i + 1) == n);
          end
        end
      end
      obrb_pkg::KIND_SHIFT: begin
        if (count != '0) begin
          rd_idx    = (rd_idx + 32'(count)) % cap;
          ring_full = 1'b0;
        end
        push_result('0, 1'b0, 1'b1);
      end
      default: begin
        empty_mirror();
        push_result('0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  // Trim a peek so that it never reaches a store entry left unwritten
  function automatic logic [CAP_W-1:0] readable_count(logic [CAP_W-1:0] want);
    int unsigned cap;
    int unsigned n;
    int unsigned i;
    cap = cap_eff();
    n = 32'(want);
    if (n > occ_now()) n = occ_now();
    if (n > BURST) n = BURST;
    for (i = 0; i < n; i++) begin
      if (!mirror_written[ADDR_W'((rd_idx % cap + i) % cap)]) return CAP_W'(i);
    end
    return want;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, or a counted hold-off when one is asked
  always @(negedge clk) begin
    if (holdoff_kick != holdoff_seen) begin
      holdoff_seen = holdoff_kick;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      out_ch.ready <= 1'b0;
      holdoff_left--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    ring_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        want = pending_results.pop_front();
        if (out_ch.data_out !== want.data_out)
          report_mismatch($sformatf("data_out %h, want %h", out_ch.data_out, want.data_out));
        if (out_ch.has_data !== want.has_data)
          report_mismatch($sformatf("has_data %b, want %b", out_ch.has_data, want.has_data));
        if (out_ch.last !== want.last)
          report_mismatch($sformatf("last %b, want %b", out_ch.last, want.last));
        if (out_ch.occupancy !== want.occupancy)
          report_mismatch($sformatf("occupancy %0d, want %0d",
                                    out_ch.occupancy, want.occupancy));
        if (out_ch.is_full !== want.is_full)
          report_mismatch($sformatf("is_full %b, want %b", out_ch.is_full, want.is_full));
        if (out_ch.is_empty !== want.is_empty)
          report_mismatch($sformatf("is_empty %b, want %b", out_ch.is_empty, want.is_empty));
      end
    end
  end

  // Send one request; the prediction is made in send order, so it matches
  // the order of acceptance
  task automatic send_request(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] data,
                              logic [CAP_W-1:0] count);
    int unsigned idle;
    logic [CAP_W-1:0] cnt;
    idle = 0;
    while (idle < MAX_GAP && $urandom_range(99) < send_idle_pct) idle++;
    if (idle > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (idle - 1) @(negedge clk);
    end
    cnt = count;
    if (kind == obrb_pkg::KIND_PEEK) cnt = readable_count(count);
    @(negedge clk);
    mirror_request(kind, data, cnt);
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= kind;
    in_ch.data_in <= data;
    in_ch.count   <= cnt;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    requests_sent++;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain_block();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Capacity write, only with the block idle
  task automatic write_capacity(logic [CAP_W-1:0] value);
    drain_block();
    @(negedge clk);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.capacity <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cap_reg = value;
    empty_mirror();
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [CAP_W-1:0] pick_peek_count();
    case ($urandom_range(3))
      0:       return CAP_W'($urandom_range(0, 8));
      1:       return CAP_W'($urandom_range(1, BURST + 8));
      2:       return CAP_W'($urandom_range(0, COUNT_MAX));
      default: return CAP_W'(occ_now());
    endcase
  endfunction

  function automatic logic [CAP_W-1:0] pick_shift_count();
    case ($urandom_range(5))
      0:       return '0;
      1:       return CAP_W'($urandom_range(0, COUNT_MAX));
      2:       return CAP_W'($urandom_range(1, cap_eff()));
      default: return CAP_W'($urandom_range(1, occ_now() + 1));
    endcase
  endfunction

  // Empty edge at reset capacity, writes, discards of zero and one, rewind
  task automatic test_reset_state();
    send_request(obrb_pkg::KIND_PEEK,   8'h00, 13'd5);
    send_request(obrb_pkg::KIND_SHIFT,  8'hFF, 13'd0);
    send_request(obrb_pkg::KIND_WRITE,  8'h00, 13'd0);
    send_request(obrb_pkg::KIND_WRITE,  8'hFF, 13'h1FFF);
    send_request(obrb_pkg::KIND_PEEK,   8'h00, 13'h1FFF);
    send_request(obrb_pkg::KIND_SHIFT,  8'h00, 13'd0);
    send_request(obrb_pkg::KIND_SHIFT,  8'h00, 13'd1);
    send_request(obrb_pkg::KIND_PEEK,   8'h00, 13'd4096);
    send_request(obrb_pkg::KIND_REWIND, 8'hFF, 13'h1FFF);
    send_request(obrb_pkg::KIND_PEEK,   8'h00, 13'd1);
  endtask

  // Full flag, overwrite of the oldest byte, discard past occupancy
  task automatic test_overwrite_when_full();
    write_capacity(13'd3);
    send_request(obrb_pkg::KIND_WRITE,  8'hA5, 13'd0);
    send_request(obrb_pkg::KIND_WRITE,  8'h5A, 13'd0);
    send_request(obrb_pkg::KIND_WRITE,  8'hC3, 13'd0);
    send_request(obrb_pkg::KIND_WRITE,  8'h3C, 13'd0);
    send_request(obrb_pkg::KIND_PEEK,   8'h00, 13'd64);
    send_request(obrb_pkg::KIND_WRITE,  8'h81, 13'd0);
    send_request(obrb_pkg::KIND_SHIFT,  8'h00, 13'd4);
    send_request(obrb_pkg::KIND_PEEK,   8'h00, 13'd3);
    send_request(obrb_pkg::KIND_REWIND, 8'h00, 13'd0);
  endtask

  // Capacity zero acts as one, above the store acts as the store
  task automatic test_capacity_clamp();
    write_capacity(13'd0);
    send_request(obrb_pkg::KIND_WRITE, 8'h11, 13'd0);
    send_request(obrb_pkg::KIND_WRITE, 8'h22, 13'd0);
    send_request(obrb_pkg::KIND_PEEK,  8'h00, 13'd2);
    write_capacity(13'h1FFF);
    send_request(obrb_pkg::KIND_WRITE, 8'h7E, 13'd0);
    send_request(obrb_pkg::KIND_PEEK,  8'h00, 13'd8);
  endtask

  // Long receiver hold-off while writes keep coming, then a burst-limited peek
  task automatic test_output_backpressure();
    int unsigned i;
    write_capacity(13'd100);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_kick   = !holdoff_kick;
    for (i = 0; i < 70; i++) send_request(obrb_pkg::KIND_WRITE, 8'($urandom), 13'd0);
    send_request(obrb_pkg::KIND_PEEK, 8'h00, 13'd4096);
  endtask

  // Random phase: mostly write bursts followed by a peek, plus noise
  task automatic random_phase(logic [CAP_W-1:0] cap_value, int unsigned s_pct,
                              int unsigned r_pct, int unsigned n_items);
    int unsigned start;
    int unsigned run;
    int unsigned limit;
    int unsigned i;
    int unsigned r;
    write_capacity(cap_value);
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    start = requests_sent;
    while (requests_sent - start < n_items) begin
      r = $urandom_range(99);
      if (r < 55) begin
        limit = (cap_eff() + 3 > 90) ? 90 : cap_eff() + 3;
        if (limit > n_items - (requests_sent - start)) begin
          limit = n_items - (requests_sent - start);
        end
        run = $urandom_range(1, limit);
        for (i = 0; i < run; i++) begin
          send_request(obrb_pkg::KIND_WRITE, 8'($urandom), 13'($urandom));
        end
        send_request(obrb_pkg::KIND_PEEK, 8'($urandom), pick_peek_count());
      end else if (r < 70) begin
        send_request(obrb_pkg::KIND_PEEK, 8'($urandom), pick_peek_count());
      end else if (r < 84) begin
        send_request(obrb_pkg::KIND_SHIFT, 8'($urandom), pick_shift_count());
      end else if (r < 90) begin
        send_request(obrb_pkg::KIND_REWIND, 8'($urandom), 13'($urandom));
      end else begin
        send_request(KIND_W'($urandom), 8'($urandom), 13'($urandom));
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.kind      = obrb_pkg::KIND_WRITE;
    in_ch.data_in   = '0;
    in_ch.count     = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.capacity = '0;
    cap_reg         = CAP_W'(DEPTH);
    empty_mirror();
    requests_sent   = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;

    // Synchronous reset
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_overwrite_when_full();
    test_capacity_clamp();
    test_output_backpressure();

    random_phase(13'd5,    0,  0,  35);
    random_phase(13'd100,  71, 0,  45);
    random_phase(13'd1,    0,  71, 25);
    random_phase(13'd17,   18, 18, 35);
    random_phase(13'h1FFF, 0,  0,  30);
    random_phase(13'd64,   0,  71, 35);
    random_phase(13'd0,    71, 0,  25);
    random_phase(13'd3,    18, 18, 30);
    random_phase(13'd4096, 0,  71, 20);

    drain_block();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
